/* sv/bpfa_pkg.sv */
// Types and codes shared by the page frame allocator.
`default_nettype none
package bpfa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_ADD     = 2'd2,
    OP_RESERVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_READ,
    S_LOAD,
    S_BIT,
    S_WB,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    M_SCAN,
    M_SET,
    M_ADD,
    M_FREE
  } mode_e;

  localparam int unsigned PAGE_SHIFT = 12;

  typedef struct packed {
    op_e         opcode;
    logic [16:0] page_count;
    logic [31:0] free_address;
    logic [63:0] range_start;
    logic [63:0] range_end;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [27:0] alloc_address;
    logic [16:0] free_total;
    logic [16:0] page_extent;
  } rsp_t;

endpackage
`default_nettype wire

/* sv/bitmap_page_frame_allocator.sv */
// Top level: bitmap page frame allocator with a page-serial sequencer.
//
// One request word enters on start when busy is low; the block then walks
// the used/free bitmap one page per cycle, pausing in S_READ and S_LOAD
// to fetch each 32-page memory word and in S_WB to write it back when marking.
// Allocate scans from LOW_RESERVED up to NUM_PAGES for a first-fit run and
// then marks the run used in a second pass; free touches one page; add and
// reserve walk their clipped page range.
// The single result word is shown on rsp_o for one cycle with valid_o high
// and busy drops the cycle after; the receiver cannot stall it.
// After reset a fill pass writes every bitmap word to all ones (every page
// used), with busy high. Counters reset to zero.
`default_nettype none
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int unsigned NUM_PAGES    = 65536,
  parameter int unsigned LOW_RESERVED = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      valid_o,
  output rsp_t      rsp_o
);

  localparam int unsigned MAP_WORDS = (NUM_PAGES + 31) / 32;
  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PW = $clog2(NUM_PAGES) + 1;
  localparam int unsigned CW = (PW > 17) ? PW : 17;
  localparam bit ALLOC_OK = LOW_RESERVED < NUM_PAGES;
  localparam int unsigned MAX_RUN = ALLOC_OK ? NUM_PAGES - LOW_RESERVED : 0;

  logic [31:0] mem_q [MAP_WORDS];
  logic [31:0] rdata_q;

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  req_t            req_q;
  logic [PW-1:0]   p_q, p_d, last_q, last_d, start_q, start_d;
  logic [CW-1:0]   run_q, run_d;
  logic [PW-1:0]   free_q, free_d, ext_q, ext_d;
  status_e         status_q, status_d;
  logic [27:0]     addr_q, addr_d;
  logic [31:0]     word_q, word_d;
  logic [AW-1:0]   wa_q, wa_d;
  logic [AW-1:0]   clr_q, clr_d;

  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [31:0]     mem_wd;
  logic [AW-1:0]   rd_addr;

  // range bounds
  logic [52:0]     rfirst, rlast, rlast_c, rfirst_c;
  logic            rempty;
  logic [PW-1:0]   pn, fit_start;
  logic            bit_used, word_end, fit;
  logic [19:0]     fpage;
  logic            free_ok;

  assign rd_addr  = AW'(p_q >> 5);
  assign pn       = p_q + PW'(1);
  assign bit_used = word_q[p_q[4:0]];
  assign word_end = (pn == last_q) || (pn[4:0] == 5'd0);
  assign fit_start = (run_q == '0) ? p_q : start_q;
  assign fit      = !bit_used && ((run_q + CW'(1)) == CW'(req_q.page_count));
  assign fpage    = req_q.free_address[31:12];
  assign free_ok  = (req_q.free_address[11:0] == 12'd0) &&
                    (32'(fpage) >= 32'(LOW_RESERVED)) && (32'(fpage) < 32'(NUM_PAGES));

  always_comb begin
    if (req_q.opcode == OP_ADD) begin
      rfirst = {1'b0, req_q.range_start[63:12]} + 53'(req_q.range_start[11:0] != 12'd0);
      rlast  = {1'b0, req_q.range_end[63:12]};
    end else begin
      rfirst = {1'b0, req_q.range_start[63:12]};
      rlast  = {1'b0, req_q.range_end[63:12]} + 53'(req_q.range_end[11:0] != 12'd0);
    end
    rlast_c  = (rlast > 53'(NUM_PAGES)) ? 53'(NUM_PAGES) : rlast;
    rfirst_c = (rfirst > 53'(NUM_PAGES)) ? 53'(NUM_PAGES) : rfirst;
    rempty   = (rfirst_c >= rlast_c) ||
               ((req_q.opcode == OP_RESERVE) && (req_q.range_end <= req_q.range_start));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (32'(clr_q) == 32'(MAP_WORDS - 1)) state_d = S_IDLE;
      S_IDLE:  if (start) state_d = S_SETUP;
      S_SETUP: begin
        unique case (req_q.opcode)
          OP_ALLOC: state_d = (!ALLOC_OK || req_q.page_count == 17'd0 ||
                               32'(req_q.page_count) > 32'(MAX_RUN)) ? S_DONE : S_READ;
          OP_FREE:  state_d = free_ok ? S_READ : S_DONE;
          default:  state_d = rempty ? S_DONE : S_READ;
        endcase
      end
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = S_BIT;
      S_BIT: begin
        if (mode_q == M_SCAN) begin
          if (fit) state_d = S_READ;
          else if (pn == last_q) state_d = S_DONE;
          else if (word_end) state_d = S_READ;
        end else if (word_end) begin
          state_d = S_WB;
        end
      end
      S_WB:    state_d = (p_q == last_q) ? S_DONE : S_READ;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    p_d      = p_q;
    last_d   = last_q;
    start_d  = start_q;
    run_d    = run_q;
    free_d   = free_q;
    ext_d    = ext_q;
    status_d = status_q;
    addr_d   = addr_q;
    word_d   = word_q;
    wa_d     = wa_q;
    clr_d    = clr_q;
    case (state_q)
      S_CLEAR: clr_d = clr_q + AW'(1);
      S_SETUP: begin
        status_d = ST_DONE;
        addr_d   = '0;
        run_d    = '0;
        unique case (req_q.opcode)
          OP_ALLOC: begin
            status_d = ST_NOFIT;
            mode_d   = M_SCAN;
            p_d      = PW'(LOW_RESERVED);
            last_d   = PW'(NUM_PAGES);
          end
          OP_FREE: begin
            if (!free_ok) status_d = ST_IGNORED;
            mode_d = M_FREE;
            p_d    = PW'(fpage);
            last_d = PW'(fpage) + PW'(1);
          end
          OP_ADD: begin
            mode_d = M_ADD;
            p_d    = PW'(rfirst_c);
            last_d = PW'(rlast_c);
          end
          default: begin
            mode_d = M_SET;
            p_d    = PW'(rfirst_c);
            last_d = PW'(rlast_c);
          end
        endcase
      end
      S_READ: wa_d = rd_addr;
      S_LOAD: word_d = rdata_q;
      S_BIT: begin
        p_d = pn;
        case (mode_q)
          M_SCAN: begin
            if (!bit_used) begin
              start_d = fit_start;
              run_d   = run_q + CW'(1);
              if (fit) begin
                status_d = ST_DONE;
                addr_d   = 28'(fit_start) << PAGE_SHIFT;
                mode_d   = M_SET;
                p_d      = fit_start;
                last_d   = fit_start + PW'(req_q.page_count);
              end
            end else begin
              run_d = '0;
            end
          end
          M_SET: begin
            if (!bit_used) begin
              word_d[p_q[4:0]] = 1'b1;
              free_d = (free_q != '0) ? free_q - PW'(1) : '0;
            end
          end
          M_ADD: begin
            if (bit_used) begin
              word_d[p_q[4:0]] = 1'b0;
              free_d = free_q + PW'(1);
              if (pn > ext_q) ext_d = pn;
            end
          end
          default: begin
            if (bit_used) begin
              word_d[p_q[4:0]] = 1'b0;
              free_d = free_q + PW'(1);
            end else begin
              status_d = ST_IGNORED;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we = (state_q == S_CLEAR) || (state_q == S_WB);
    mem_wa = (state_q == S_CLEAR) ? clr_q : wa_q;
    mem_wd = (state_q == S_CLEAR) ? '1 : word_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (state_q == S_READ) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      free_q  <= '0;
      ext_q   <= '0;
      mode_q  <= M_SCAN;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
      ext_q   <= ext_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) req_q <= req_i;
    p_q      <= p_d;
    last_q   <= last_d;
    start_q  <= start_d;
    run_q    <= run_d;
    status_q <= status_d;
    addr_q   <= addr_d;
    word_q   <= word_d;
    wa_q     <= wa_d;
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = (state_q == S_DONE);
  always_comb begin
    rsp_o.status        = status_q;
    rsp_o.alloc_address = addr_q;
    rsp_o.free_total    = 17'(free_q);
    rsp_o.page_extent   = 17'(ext_q);
  end

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy) else $error("no idle after result");
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.status != ST_DONE |-> rsp_o.alloc_address == '0)
    else $error("address on failed op");
  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_q) <= 32'(NUM_PAGES) && 32'(ext_q) <= 32'(NUM_PAGES))
    else $error("counter beyond page count");

endmodule
`default_nettype wire

/* dv/tb_bitmap_page_frame_allocator.sv */
// Testbench for the bitmap page frame allocator: random and directed requests vs. a scoreboard.
`timescale 1ns / 100ps
module tb_bitmap_page_frame_allocator;
  import bpfa_pkg::*;

  localparam int unsigned NUM_PAGES    = 65536;
  localparam int unsigned LOW_RESERVED = 1024;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned POOL_HI      = 1280;
  localparam int unsigned NUM_RANDOM   = 275;
  localparam int unsigned STALL_LIMIT  = 600000;

  class frame_scoreboard;
    bit          used[NUM_PAGES];
    int unsigned free_cnt;
    int unsigned extent;
    rsp_t        pending[$];
    int          errors;

    function new();
      foreach (used[i]) used[i] = 1'b1;
      free_cnt = 0;
      extent   = 0;
      errors   = 0;
    endfunction

    function int find_run(int unsigned count);
      int unsigned run;
      int unsigned first;
      run   = 0;
      first = 0;
      if (count == 0 || count > NUM_PAGES - LOW_RESERVED) return -1;
      for (int unsigned p = LOW_RESERVED; p < NUM_PAGES; p++) begin
        if (!used[p]) begin
          if (run == 0) first = p;
          run++;
          if (run == count) return first;
        end else begin
          run = 0;
        end
      end
      return -1;
    endfunction

    function void note(req_t r);
      rsp_t            x;
      int              found;
      int unsigned     pg;
      longint unsigned lo;
      longint unsigned hi;
      x = '0;
      x.status = ST_DONE;
      case (r.opcode)
        OP_ALLOC: begin
          found = find_run(r.page_count);
          if (found < 0) begin
            x.status = ST_NOFIT;
          end else begin
            for (int unsigned i = 0; i < r.page_count; i++) used[found + i] = 1'b1;
            free_cnt = (free_cnt > r.page_count) ? free_cnt - r.page_count : 0;
            x.alloc_address = 28'(found << PAGE_SHIFT);
          end
        end
        OP_FREE: begin
          pg = r.free_address >> PAGE_SHIFT;
          if (r.free_address[11:0] != 0 || pg < LOW_RESERVED || pg >= NUM_PAGES || !used[pg])
            x.status = ST_IGNORED;
          else begin
            used[pg] = 1'b0;
            free_cnt++;
          end
        end
        OP_ADD: begin
          lo = (r.range_start >> PAGE_SHIFT) + (r.range_start[11:0] != 0);
          hi = r.range_end >> PAGE_SHIFT;
          if (hi > NUM_PAGES) hi = NUM_PAGES;
          for (longint unsigned p = lo; p < hi; p++) begin
            if (used[p]) begin
              used[p] = 1'b0;
              free_cnt++;
              if (p + 1 > extent) extent = 32'(p + 1);
            end
          end
        end
        default: begin
          if (r.range_end > r.range_start) begin
            lo = r.range_start >> PAGE_SHIFT;
            hi = (r.range_end >> PAGE_SHIFT) + (r.range_end[11:0] != 0);
            if (hi > NUM_PAGES) hi = NUM_PAGES;
            for (longint unsigned p = lo; p < hi; p++) begin
              if (!used[p]) begin
                used[p] = 1'b1;
                free_cnt = (free_cnt > 0) ? free_cnt - 1 : 0;
              end
            end
          end
        end
      endcase
      x.free_total  = 17'(free_cnt);
      x.page_extent = 17'(extent);
      pending.push_back(x);
    endfunction

    function void check(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.alloc_address !== want.alloc_address) begin
        $error("alloc_address: expected %h, got %h", want.alloc_address, got.alloc_address);
        errors++;
      end
      if (got.free_total !== want.free_total) begin
        $error("free_total: expected %0d, got %0d", want.free_total, got.free_total);
        errors++;
      end
      if (got.page_extent !== want.page_extent) begin
        $error("page_extent: expected %0d, got %0d", want.page_extent, got.page_extent);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic valid_o;
  rsp_t rsp_o;

  frame_scoreboard sb;
  int unsigned     quiet_cycles;
  int unsigned     idle_pct;

  bitmap_page_frame_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check(rsp_o);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic req_t mk_req(op_e op, int unsigned cnt, logic [31:0] fa,
                                  logic [63:0] rs, logic [63:0] re);
    req_t r;
    r.opcode       = op;
    r.page_count   = 17'(cnt);
    r.free_address = fa;
    r.range_start  = rs;
    r.range_end    = re;
    return r;
  endfunction

  task automatic send(req_t r);
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    sb.note(r);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      req_i = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  function automatic logic [63:0] pool_addr();
    return 64'(LOW_RESERVED * PAGE_BYTES + $urandom_range(0, (POOL_HI - LOW_RESERVED) * PAGE_BYTES));
  endfunction

  function automatic logic [63:0] far_addr();
    logic [63:0] a;
    a = {$urandom, $urandom};
    a[63] = 1'b1;
    return a;
  endfunction

  function automatic req_t rand_req();
    int unsigned r;
    int unsigned cnt;
    logic [63:0] s;
    logic [63:0] e;
    r = $urandom_range(99);
    s = pool_addr();
    e = s + $urandom_range(0, 16 * PAGE_BYTES);
    if (e > POOL_HI * PAGE_BYTES) e = POOL_HI * PAGE_BYTES;
    if (r < 35) begin
      if ($urandom_range(15) == 0)
        return mk_req(OP_ALLOC, 17'h10000 | $urandom, $urandom, {$urandom, $urandom},
                      {$urandom, $urandom});
      cnt = ($urandom_range(3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 4);
      if (sb.find_run(cnt) >= 0) return mk_req(OP_ALLOC, cnt, $urandom, s, e);
      return mk_req(OP_ADD, cnt, $urandom, s, e);
    end else if (r < 60) begin
      if ($urandom_range(7) == 0)
        return mk_req(OP_FREE, $urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
      return mk_req(OP_FREE, $urandom, $urandom_range(1000, POOL_HI) * PAGE_BYTES, s, e);
    end else if (r < 80) begin
      if ($urandom_range(7) == 0)
        return mk_req(OP_ADD, $urandom, $urandom, far_addr(), {$urandom, $urandom});
      return mk_req(OP_ADD, $urandom, $urandom, s, e);
    end else begin
      if ($urandom_range(7) == 0)
        return mk_req(OP_RESERVE, $urandom, $urandom, far_addr(), {$urandom, $urandom});
      if ($urandom_range(7) == 0)
        return mk_req(OP_RESERVE, $urandom, $urandom, e, s);
      e = s + $urandom_range(1, 4 * PAGE_BYTES);
      if (e > POOL_HI * PAGE_BYTES) e = POOL_HI * PAGE_BYTES;
      return mk_req(OP_RESERVE, $urandom, $urandom, s, e);
    end
  endfunction

  initial begin
    int unsigned pcts[4];
    pcts = '{0, 48, 0, 32};
    sb       = new();
    rst_ni   = 1'b0;
    start    = 1'b0;
    req_i    = '0;
    idle_pct = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: failures first, then the whole-map extremes
    send(mk_req(OP_ALLOC, 1, 0, 0, 0));
    send(mk_req(OP_ALLOC, 0, 0, 0, 0));
    send(mk_req(OP_ALLOC, NUM_PAGES - LOW_RESERVED + 1, 0, 0, 0));
    send(mk_req(OP_ALLOC, 17'h1FFFF, 0, 0, 0));
    send(mk_req(OP_FREE, 0, 32'h0040_0001, 0, 0));
    send(mk_req(OP_FREE, 0, 32'h0000_0000, 0, 0));
    send(mk_req(OP_FREE, 0, 32'hFFFF_F000, 0, 0));
    send(mk_req(OP_FREE, 0, 32'h0040_0000, 0, 0));
    send(mk_req(OP_FREE, 0, 32'h0040_0000, 0, 0));
    send(mk_req(OP_ADD, 0, 0, 64'h50_0000, 64'h40_0000));
    send(mk_req(OP_ADD, 0, 0, 64'h40_0001, 64'h40_2FFF));
    send(mk_req(OP_ADD, 0, 0, 64'h0, '1));
    send(mk_req(OP_ALLOC, NUM_PAGES - LOW_RESERVED, 0, 0, 0));
    send(mk_req(OP_RESERVE, 0, 0, 64'h40_0000, 64'h40_0000));
    send(mk_req(OP_RESERVE, 0, 0, 64'h0, '1));
    send(mk_req(OP_RESERVE, 0, 0, '1, 64'h0));
    send(mk_req(OP_ADD, 0, 0, '1, '1));
    send(mk_req(OP_ADD, 0, 0, 64'h40_0000, 64'h48_0000));
    send(mk_req(OP_ALLOC, 128, 0, 0, 0));
    send(mk_req(OP_ADD, 0, 0, 64'h40_0000, 64'h48_0000));

    for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
      idle_pct = pcts[(i * 4) / NUM_RANDOM];
      send(rand_req());
    end
    @(negedge clk_i);
    start = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
